### rtl/r2y_pkg.sv
// Shared types, constants and arithmetic helpers of the RGB to YCbCr 4:2:0 converter.
`default_nettype none

package r2y_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 18;
    localparam int OFS_W     = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic signed [SUM_W-1:0] Y_R  = 18'sd66;
    localparam logic signed [SUM_W-1:0] Y_G  = 18'sd129;
    localparam logic signed [SUM_W-1:0] Y_B  = 18'sd25;
    localparam logic signed [SUM_W-1:0] U_R  = -18'sd38;
    localparam logic signed [SUM_W-1:0] U_G  = -18'sd74;
    localparam logic signed [SUM_W-1:0] U_B  = 18'sd112;
    localparam logic signed [SUM_W-1:0] V_R  = 18'sd112;
    localparam logic signed [SUM_W-1:0] V_G  = -18'sd94;
    localparam logic signed [SUM_W-1:0] V_B  = -18'sd18;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 18'sd128;

    localparam logic signed [OFS_W-1:0] Y_OFFSET = 11'sd16;
    localparam logic signed [OFS_W-1:0] C_OFFSET = 11'sd128;
    localparam logic signed [OFS_W-1:0] BYTE_MAX = 11'sd255;

    // Position flags of one pixel, produced by the frame counters
    typedef struct packed {
        logic keep;  // even column and even row
        logic last;  // last column of last row
    } r2y_pos_t;

    // floor(sum / 256) + offset, clamped to 0..255
    function automatic logic [PIX_W-1:0] component(
        input logic signed [SUM_W-1:0] sum,
        input logic signed [OFS_W-1:0] offset
    );
        logic signed [SUM_W-9:0] quo;
        logic signed [OFS_W-1:0] val;
        begin
            quo = sum[SUM_W-1:8];
            val = {quo[SUM_W-9], quo} + offset;
            if (val > BYTE_MAX) begin
                component = 8'd255;
            end
            else if (val < 0) begin
                component = 8'd0;
            end
            else begin
                component = val[PIX_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/r2y_frame_ctrl.sv
// Frame size registers and raster column/row counters.
`default_nettype none

module r2y_frame_ctrl #(
    parameter int MAX_DIM = 4096,
    parameter int CNT_W   = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [r2y_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [r2y_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           advance,
    output r2y_pkg::r2y_pos_t                   pos
);

    localparam int CMP_W = ((CNT_W + 1) > r2y_pkg::CFG_W) ? (CNT_W + 1) : r2y_pkg::CFG_W;

    logic [r2y_pkg::CFG_W-1:0] frame_width_reg;
    logic [r2y_pkg::CFG_W-1:0] frame_height_reg;
    logic [CNT_W-1:0]          column_count_reg;
    logic [CNT_W-1:0]          column_count_next;
    logic [CNT_W-1:0]          row_count_reg;
    logic [CNT_W-1:0]          row_count_next;

    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] height_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;
    logic [CMP_W-1:0] last_col_idx;
    logic [CMP_W-1:0] last_row_idx;
    logic             last_col;
    logic             last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= r2y_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= r2y_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                r2y_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                r2y_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // Zero acts as one, anything above MAX_DIM as MAX_DIM
    always_comb
    begin
        width_ext  = CMP_W'(frame_width_reg);
        height_ext = CMP_W'(frame_height_reg);

        if (width_ext == '0)
            width_eff = CMP_W'(1);
        else if (width_ext > CMP_W'(MAX_DIM))
            width_eff = CMP_W'(MAX_DIM);
        else
            width_eff = width_ext;

        if (height_ext == '0)
            height_eff = CMP_W'(1);
        else if (height_ext > CMP_W'(MAX_DIM))
            height_eff = CMP_W'(MAX_DIM);
        else
            height_eff = height_ext;

        last_col_idx = width_eff - CMP_W'(1);
        last_row_idx = height_eff - CMP_W'(1);
    end

    // A counter beyond a freshly shrunk size still wraps on this pixel
    assign last_col = CMP_W'(column_count_reg) >= last_col_idx;
    assign last_row = CMP_W'(row_count_reg) >= last_row_idx;

    assign pos.keep = !column_count_reg[0] && !row_count_reg[0];
    assign pos.last = last_col && last_row;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (advance)
        begin
            if (last_col)
            begin
                column_count_next = '0;
                row_count_next    = last_row ? '0 : row_count_reg + CNT_W'(1);
            end
            else
            begin
                column_count_next = column_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/r2y_csc.sv
// Color space conversion: constant-coefficient multiply-adds, rounding, offset and clamp.
`default_nettype none

module r2y_csc (
    input  wire logic [r2y_pkg::PIX_W-1:0] red,
    input  wire logic [r2y_pkg::PIX_W-1:0] green,
    input  wire logic [r2y_pkg::PIX_W-1:0] blue,
    input  wire logic                      keep,
    output logic      [r2y_pkg::PIX_W-1:0] luma,
    output logic      [r2y_pkg::PIX_W-1:0] chroma_u,
    output logic      [r2y_pkg::PIX_W-1:0] chroma_v
);

    logic signed [r2y_pkg::SUM_W-1:0] r_s;
    logic signed [r2y_pkg::SUM_W-1:0] g_s;
    logic signed [r2y_pkg::SUM_W-1:0] b_s;
    logic signed [r2y_pkg::SUM_W-1:0] y_sum;
    logic signed [r2y_pkg::SUM_W-1:0] u_sum;
    logic signed [r2y_pkg::SUM_W-1:0] v_sum;

    assign r_s = $signed({{(r2y_pkg::SUM_W - r2y_pkg::PIX_W){1'b0}}, red});
    assign g_s = $signed({{(r2y_pkg::SUM_W - r2y_pkg::PIX_W){1'b0}}, green});
    assign b_s = $signed({{(r2y_pkg::SUM_W - r2y_pkg::PIX_W){1'b0}}, blue});

    assign y_sum = r2y_pkg::Y_R * r_s + r2y_pkg::Y_G * g_s + r2y_pkg::Y_B * b_s
                 + r2y_pkg::ROUND_BIAS;
    assign u_sum = r2y_pkg::U_R * r_s + r2y_pkg::U_G * g_s + r2y_pkg::U_B * b_s
                 + r2y_pkg::ROUND_BIAS;
    assign v_sum = r2y_pkg::V_R * r_s + r2y_pkg::V_G * g_s + r2y_pkg::V_B * b_s
                 + r2y_pkg::ROUND_BIAS;

    assign luma     = r2y_pkg::component(y_sum, r2y_pkg::Y_OFFSET);
    // Chroma of dropped samples reads zero
    assign chroma_u = keep ? r2y_pkg::component(u_sum, r2y_pkg::C_OFFSET) : '0;
    assign chroma_v = keep ? r2y_pkg::component(v_sum, r2y_pkg::C_OFFSET) : '0;

endmodule

`default_nettype wire

### rtl/rgba_to_yuv420_converter_unit.sv
// Top level of the RGB to YCbCr 4:2:0 converter: handshake pipeline around counters and CSC.
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------------------
//  in        sink       in_valid / in_stall   red, green, blue
//  out       source     out_valid / out_stall luma, chroma_u, chroma_v, chroma_valid,
//                                             frame_last
//  cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data (ready is always high)
//
// One pixel per clock sustained while out_stall is low; an accepted pixel loads the
// input register, then the result register (CSC math between them) once the result
// side is free, and out_valid then marks it as ready to be taken.
// Reset loads 640x480 and zeroes the column and row counters.
// A stalled result holds in the result register while the input register can
// still take one more pixel; in_stall rises only when both stages are full.
`default_nettype none

module rgba_to_yuv420_converter_unit #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [r2y_pkg::PIX_W-1:0]     red,
    input  wire logic [r2y_pkg::PIX_W-1:0]     green,
    input  wire logic [r2y_pkg::PIX_W-1:0]     blue,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [r2y_pkg::PIX_W-1:0]     luma,
    output logic      [r2y_pkg::PIX_W-1:0]     chroma_u,
    output logic      [r2y_pkg::PIX_W-1:0]     chroma_v,
    output logic                               chroma_valid,
    output logic                               frame_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [r2y_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    r2y_pkg::r2y_pos_t pos;
    r2y_pkg::r2y_pos_t pos_reg;

    logic                      in_accept;
    logic                      s2_advance;
    logic                      pix_valid_reg;
    logic                      pix_valid_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [r2y_pkg::PIX_W-1:0] red_reg;
    logic [r2y_pkg::PIX_W-1:0] green_reg;
    logic [r2y_pkg::PIX_W-1:0] blue_reg;
    logic [r2y_pkg::PIX_W-1:0] luma_calc;
    logic [r2y_pkg::PIX_W-1:0] chroma_u_calc;
    logic [r2y_pkg::PIX_W-1:0] chroma_v_calc;
    logic [r2y_pkg::PIX_W-1:0] luma_reg;
    logic [r2y_pkg::PIX_W-1:0] chroma_u_reg;
    logic [r2y_pkg::PIX_W-1:0] chroma_v_reg;
    logic                      chroma_valid_reg;
    logic                      frame_last_reg;

    assign cfg_ready  = 1'b1;
    assign s2_advance = !out_valid_reg || !out_stall;
    assign in_stall   = pix_valid_reg && !s2_advance;
    assign in_accept  = in_valid && !in_stall;

    r2y_frame_ctrl #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .pos       (pos)
    );

    r2y_csc u_csc (
        .red      (red_reg),
        .green    (green_reg),
        .blue     (blue_reg),
        .keep     (pos_reg.keep),
        .luma     (luma_calc),
        .chroma_u (chroma_u_calc),
        .chroma_v (chroma_v_calc)
    );

    always_comb
    begin
        if (in_accept)
            pix_valid_next = 1'b1;
        else if (s2_advance)
            pix_valid_next = 1'b0;
        else
            pix_valid_next = pix_valid_reg;

        out_valid_next = s2_advance ? pix_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: load on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            pos_reg   <= pos;
        end
    end

    // Result register: load a valid pixel's result unless the result is stalled
    always_ff @(posedge clk)
    begin
        if (s2_advance && pix_valid_reg)
        begin
            luma_reg         <= luma_calc;
            chroma_u_reg     <= chroma_u_calc;
            chroma_v_reg     <= chroma_v_calc;
            chroma_valid_reg <= pos_reg.keep;
            frame_last_reg   <= pos_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_u     = chroma_u_reg;
    assign chroma_v     = chroma_v_reg;
    assign chroma_valid = chroma_valid_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

### rtl/r2y_checker.sv
// Port-level checks of the converter, bound to the top level.
`default_nettype none

module r2y_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [r2y_pkg::PIX_W-1:0]     luma,
    input wire logic [r2y_pkg::PIX_W-1:0]     chroma_u,
    input wire logic [r2y_pkg::PIX_W-1:0]     chroma_v,
    input wire logic                          chroma_valid,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the result side free");

    // Studio-swing luma stays within 16..235
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (luma >= 8'd16) && (luma <= 8'd235))
        else $error("luma out of narrow range");

    // Dropped chroma samples read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chroma_valid |-> (chroma_u == '0) && (chroma_v == '0))
        else $error("chroma nonzero on a dropped sample");

    // Configuration writes are never back-pressured
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rgba_to_yuv420_converter_unit r2y_checker u_r2y_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .luma         (luma),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v),
    .chroma_valid (chroma_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
